[rtl/mff_pkg.sv]
// Package: shared types and constants of the mesh flood forwarder.
package mff_pkg;

    localparam int OWN_DEPTH_DEF     = 16;
    localparam int RELAY_DEPTH_DEF   = 16;
    localparam int HISTORY_DEPTH_DEF = 32;

    // Message types.
    localparam logic [1:0] MT_DATA = 2'd0;
    localparam logic [1:0] MT_ACK  = 2'd1;

    typedef enum logic [1:0] {
        OP_RX     = 2'd0,
        OP_SUBMIT = 2'd1,
        OP_SLOT   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_NODE_ID  = 2'd0,
        CFG_FWD_EN   = 2'd1,
        CFG_FWD_LIM  = 2'd2,
        CFG_MAX_HOPS = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_DATA_ME   = 5'd0,
        ST_ACK_ME    = 5'd1,
        ST_OTHER_ME  = 5'd2,
        ST_ECHO      = 5'd3,
        ST_ACK_IGN   = 5'd4,
        ST_OTHER_IGN = 5'd5,
        ST_EXPIRED   = 5'd6,
        ST_FWD_OFF   = 5'd7,
        ST_DUP_HIST  = 5'd8,
        ST_DUP_QUEUE = 5'd9,
        ST_QUEUED    = 5'd10,
        ST_FWD_FULL  = 5'd11,
        ST_OWN_Q     = 5'd12,
        ST_OWN_FULL  = 5'd13,
        ST_SENT_OWN  = 5'd14,
        ST_SENT_FWD  = 5'd15,
        ST_NOTHING   = 5'd16
    } t_status;

    // Work kinds handed from front to back.
    typedef enum logic [1:0] {
        K_DONE   = 2'd0,
        K_RELAY  = 2'd1,
        K_SUBMIT = 2'd2,
        K_SLOT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  msg_type;
        logic [7:0]  source;
        logic [7:0]  destination;
        logic [15:0] data_value;
        logic [3:0]  ttl;
        logic        app_ack_req;
        logic        adr_ack_req;
    } t_pkt;

    typedef struct packed {
        t_kind   kind;
        t_status status;
        t_pkt    pkt;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_HIST,
        S_SCAN_RELAY,
        S_SHIFT_OWN,
        S_SHIFT_RELAY,
        S_OUT
    } t_state;

endpackage

[rtl/mff_front.sv]
// Front end: accepts words, classifies received packets, queues jobs.
module mff_front
    import mff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  t_pkt        i_pkt,
    input  logic [7:0]  i_node_id,
    input  logic        i_fwd_en,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_pop
);

    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job n_job;
    logic acc;

    assign o_stall     = (r_cnt == 2'd2);
    assign acc         = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_job.pkt    = i_pkt;
        n_job.kind   = K_DONE;
        n_job.status = ST_NOTHING;
        case (i_op)
            OP_RX: begin
                if (i_pkt.destination == i_node_id) begin
                    n_job.status = (i_pkt.msg_type == MT_DATA) ? ST_DATA_ME :
                                   (i_pkt.msg_type == MT_ACK) ? ST_ACK_ME : ST_OTHER_ME;
                end else if (i_pkt.source == i_node_id) begin
                    n_job.status = ST_ECHO;
                end else if (i_pkt.msg_type == MT_ACK) begin
                    n_job.status = ST_ACK_IGN;
                end else if (i_pkt.msg_type != MT_DATA) begin
                    n_job.status = ST_OTHER_IGN;
                end else if (i_pkt.ttl == 4'd0) begin
                    n_job.status = ST_EXPIRED;
                end else if (!i_fwd_en) begin
                    n_job.status = ST_FWD_OFF;
                end else begin
                    n_job.kind = K_RELAY;
                end
            end
            OP_SUBMIT: n_job.kind = K_SUBMIT;
            OP_SLOT:   n_job.kind = K_SLOT;
            default:   n_job.kind = K_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_job_pop};
        end
    end

endmodule

[rtl/mff_back.sv]
// Back end: queues, duplicate scan, history ring and transmit.
module mff_back
    import mff_pkg::*;
#(
    parameter int OWN_DEPTH     = OWN_DEPTH_DEF,
    parameter int RELAY_DEPTH   = RELAY_DEPTH_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_pop,
    input  logic [7:0]  i_node_id,
    input  logic [15:0] i_fwd_limit,
    input  logic [3:0]  i_max_hops,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_status,
    output logic        o_tx_valid,
    output t_pkt        o_tx_pkt,
    output logic [7:0]  o_tx_via
);

    localparam int OW = $clog2(OWN_DEPTH + 1);
    localparam int RW = $clog2(RELAY_DEPTH + 1);
    localparam int HW = $clog2(HISTORY_DEPTH + 1);
    localparam int OA = (OWN_DEPTH > 1) ? $clog2(OWN_DEPTH) : 1;
    localparam int RA = (RELAY_DEPTH > 1) ? $clog2(RELAY_DEPTH) : 1;
    localparam int HA = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW = (HW > RW) ? HW : RW;

    // Queues are circular buffers; head pointer plus count.
    t_pkt r_own [OWN_DEPTH];
    t_pkt r_rel [RELAY_DEPTH];
    t_pkt r_hist [HISTORY_DEPTH];
    logic [OA-1:0] r_own_hd;
    logic [OW-1:0] r_own_cnt;
    logic [RA-1:0] r_rel_hd;
    logic [RW-1:0] r_rel_cnt;
    logic [HW-1:0] r_hist_fill;
    logic [HA-1:0] r_hist_nx;
    logic [15:0]   r_fwd_tot;

    t_state r_st, n_st;
    logic [SW-1:0] r_idx, n_idx;
    t_pkt r_cur;
    t_pkt r_rd;
    logic r_rd_ok;

    logic       r_ov, r_otv;
    logic [4:0] r_ost;
    t_pkt       r_opkt;
    logic [7:0] r_ovia;

    logic [OA-1:0] own_tail;
    logic [RA-1:0] rel_tail, rel_rd_addr;
    logic [HA-1:0] hist_rd_addr;
    logic out_free, hit;
    logic n_fin;
    logic [4:0] n_fst;
    logic n_ftx;
    t_pkt n_fpkt;
    logic n_push_rel, n_push_own, n_pop_own, n_pop_rel;
    logic n_rd_hist, n_rd_rel;

    function automatic logic [OA-1:0] own_add(input logic [OA-1:0] a, input logic [OW-1:0] b);
        logic [OW:0] s;
        s = {1'b0, OW'(a)} + {1'b0, b};
        if (s >= (OW+1)'(OWN_DEPTH)) s = s - (OW+1)'(OWN_DEPTH);
        return s[OA-1:0];
    endfunction

    function automatic logic [RA-1:0] rel_add(input logic [RA-1:0] a, input logic [SW-1:0] b);
        logic [SW+RA:0] s;
        s = {{(SW+1){1'b0}}, a} + {{(RA+1){1'b0}}, b};
        if (s >= (SW+RA+1)'(RELAY_DEPTH)) s = s - (SW+RA+1)'(RELAY_DEPTH);
        return s[RA-1:0];
    endfunction

    assign own_tail     = own_add(r_own_hd, r_own_cnt);
    assign rel_tail     = rel_add(r_rel_hd, SW'(r_rel_cnt));
    assign rel_rd_addr  = rel_add(r_rel_hd, r_idx);
    assign hist_rd_addr = r_idx[HA-1:0];
    assign out_free     = !r_ov || !i_stall;
    assign hit = r_rd_ok && r_rd.msg_type == r_cur.msg_type &&
                 r_rd.data_value == r_cur.data_value &&
                 r_rd.source == r_cur.source && r_rd.destination == r_cur.destination;

    always_comb begin
        n_st = r_st;
        n_idx = r_idx;
        n_fin = 1'b0;
        n_fst = ST_NOTHING;
        n_ftx = 1'b0;
        n_fpkt = '0;
        n_push_rel = 1'b0;
        n_push_own = 1'b0;
        n_pop_own = 1'b0;
        n_pop_rel = 1'b0;
        n_rd_hist = 1'b0;
        n_rd_rel = 1'b0;
        o_job_pop = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_job_valid && out_free) begin
                    case (i_job.kind)
                        K_RELAY: begin
                            n_idx = '0;
                            n_st = S_SCAN_HIST;
                        end
                        K_SUBMIT: begin
                            o_job_pop = 1'b1;
                            n_fin = 1'b1;
                            if (r_own_cnt == OW'(OWN_DEPTH)) begin
                                n_fst = ST_OWN_FULL;
                            end else begin
                                n_fst = ST_OWN_Q;
                                n_push_own = 1'b1;
                            end
                        end
                        K_SLOT: begin
                            o_job_pop = 1'b1;
                            n_fin = 1'b1;
                            if (r_own_cnt != '0) begin
                                n_fst = ST_SENT_OWN;
                                n_ftx = 1'b1;
                                n_fpkt = r_own[r_own_hd];
                                n_fpkt.source = i_node_id;
                                n_pop_own = 1'b1;
                            end else if (r_rel_cnt != '0 &&
                                         (i_fwd_limit == 16'd0 || r_fwd_tot < i_fwd_limit)) begin
                                n_fst = ST_SENT_FWD;
                                n_ftx = 1'b1;
                                n_fpkt = r_rel[r_rel_hd];
                                n_pop_rel = 1'b1;
                            end
                        end
                        default: begin
                            o_job_pop = 1'b1;
                            n_fin = 1'b1;
                            n_fst = i_job.status;
                        end
                    endcase
                end
            end
            S_SCAN_HIST: begin
                // one history entry read per cycle; hit checked on the registered entry
                if (hit) begin
                    o_job_pop = 1'b1;
                    n_fin = 1'b1;
                    n_fst = ST_DUP_HIST;
                    n_st = S_IDLE;
                end else if (r_idx < SW'(r_hist_fill)) begin
                    n_rd_hist = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_idx = '0;
                    n_st = S_SCAN_RELAY;
                end
            end
            S_SCAN_RELAY: begin
                if (hit) begin
                    o_job_pop = 1'b1;
                    n_fin = 1'b1;
                    n_fst = ST_DUP_QUEUE;
                    n_st = S_IDLE;
                end else if (r_idx < SW'(r_rel_cnt)) begin
                    n_rd_rel = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else begin
                    o_job_pop = 1'b1;
                    n_fin = 1'b1;
                    n_st = S_IDLE;
                    if (r_rel_cnt == RW'(RELAY_DEPTH)) begin
                        n_fst = ST_FWD_FULL;
                    end else begin
                        n_fst = ST_QUEUED;
                        n_push_rel = 1'b1;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE) r_cur <= i_job.pkt;
        if (n_rd_hist) r_rd <= r_hist[hist_rd_addr];
        if (n_rd_rel)  r_rd <= r_rel[rel_rd_addr[RA-1:0]];
        if (n_push_own) begin
            r_own[own_tail] <= '{i_job.pkt.msg_type, 8'd0, i_job.pkt.destination,
                                 i_job.pkt.data_value, i_max_hops,
                                 i_job.pkt.app_ack_req, i_job.pkt.adr_ack_req};
        end
        if (n_push_rel) begin
            r_rel[rel_tail] <= '{r_cur.msg_type, r_cur.source, r_cur.destination,
                                 r_cur.data_value, r_cur.ttl - 4'd1,
                                 r_cur.app_ack_req, r_cur.adr_ack_req};
        end
        if (n_pop_rel) r_hist[r_hist_nx] <= r_rel[r_rel_hd];
        if (n_fin) begin
            r_ost  <= n_fst;
            r_otv  <= n_ftx;
            r_opkt <= n_fpkt;
            r_ovia <= n_ftx ? i_node_id : 8'd0;
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_idx <= '0;
            r_rd_ok <= 1'b0;
            r_own_hd <= '0;
            r_own_cnt <= '0;
            r_rel_hd <= '0;
            r_rel_cnt <= '0;
            r_hist_fill <= '0;
            r_hist_nx <= '0;
            r_fwd_tot <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_idx <= n_idx;
            r_rd_ok <= n_rd_hist || n_rd_rel;
            if (n_fin) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (n_push_own) r_own_cnt <= r_own_cnt + 1'b1;
            if (n_pop_own) begin
                r_own_cnt <= r_own_cnt - 1'b1;
                r_own_hd <= own_add(r_own_hd, OW'(1));
            end
            if (n_push_rel) r_rel_cnt <= r_rel_cnt + 1'b1;
            if (n_pop_rel) begin
                r_rel_cnt <= r_rel_cnt - 1'b1;
                r_rel_hd <= rel_add(r_rel_hd, SW'(1));
                if (r_fwd_tot != 16'hFFFF) r_fwd_tot <= r_fwd_tot + 16'd1;
                if (r_hist_fill != HW'(HISTORY_DEPTH)) r_hist_fill <= r_hist_fill + 1'b1;
                if (r_hist_nx == HA'(HISTORY_DEPTH - 1)) r_hist_nx <= '0;
                else r_hist_nx <= r_hist_nx + 1'b1;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_status   = r_ost;
    assign o_tx_valid = r_otv;
    assign o_tx_pkt   = r_opkt;
    assign o_tx_via   = r_ovia;

endmodule

[rtl/mesh_flood_forwarder.sv]
// Top level of the mesh flood forwarder.
// Mesh flooding relay. Each word is an operation: a received packet, an own
// packet submit, a transmit slot or no operation; each gives one result word.
// A relayed data packet scans the forwarded history and the relay queue one
// entry per cycle through a single read port.
// A two-entry job queue decouples the classifying front from the back end.
module mesh_flood_forwarder
    import mff_pkg::*;
#(
    parameter int OWN_DEPTH     = OWN_DEPTH_DEF,
    parameter int RELAY_DEPTH   = RELAY_DEPTH_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_msg_type,
    input  logic [7:0]  i_source,
    input  logic [7:0]  i_destination,
    input  logic [15:0] i_data_value,
    input  logic [3:0]  i_ttl,
    input  logic        i_app_ack_req,
    input  logic        i_adr_ack_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_status,
    output logic        o_tx_valid,
    output logic [1:0]  o_tx_msg_type,
    output logic [7:0]  o_tx_source,
    output logic [7:0]  o_tx_destination,
    output logic [7:0]  o_tx_via,
    output logic [15:0] o_tx_data_value,
    output logic [3:0]  o_tx_ttl,
    output logic        o_tx_app_ack_req,
    output logic        o_tx_adr_ack_req
);

    logic [7:0]  r_node_id;
    logic        r_fwd_en;
    logic [15:0] r_fwd_limit;
    logic [3:0]  r_max_hops;
    logic job_valid, job_pop;
    t_job job;
    t_pkt in_pkt, tx_pkt;

    assign o_cfg_ready = 1'b1;
    assign in_pkt = '{i_msg_type, i_source, i_destination, i_data_value, i_ttl,
                      i_app_ack_req, i_adr_ack_req};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= 8'd0;
            r_fwd_en    <= 1'b1;
            r_fwd_limit <= 16'd0;
            r_max_hops  <= 4'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ID:  r_node_id   <= i_cfg_data[7:0];
                CFG_FWD_EN:   r_fwd_en    <= i_cfg_data[0];
                CFG_FWD_LIM:  r_fwd_limit <= i_cfg_data;
                CFG_MAX_HOPS: r_max_hops  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    mff_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_pkt       (in_pkt),
        .i_node_id   (r_node_id),
        .i_fwd_en    (r_fwd_en),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    mff_back #(
        .OWN_DEPTH     (OWN_DEPTH),
        .RELAY_DEPTH   (RELAY_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_node_id   (r_node_id),
        .i_fwd_limit (r_fwd_limit),
        .i_max_hops  (r_max_hops),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_tx_valid  (o_tx_valid),
        .o_tx_pkt    (tx_pkt),
        .o_tx_via    (o_tx_via)
    );

    assign o_tx_msg_type    = tx_pkt.msg_type;
    assign o_tx_source      = tx_pkt.source;
    assign o_tx_destination = tx_pkt.destination;
    assign o_tx_data_value  = tx_pkt.data_value;
    assign o_tx_ttl         = tx_pkt.ttl;
    assign o_tx_app_ack_req = tx_pkt.app_ack_req;
    assign o_tx_adr_ack_req = tx_pkt.adr_ack_req;

endmodule

[sim/mesh_flood_forwarder_tb.sv]
// Testbench: mesh flood forwarder checked word by word against an in-bench predictor.
`timescale 1ns / 100ps

module mesh_flood_forwarder_tb;
    import mff_pkg::*;

    localparam int OWN_CAP   = 16;
    localparam int RELAY_CAP = 16;
    localparam int HIST_CAP  = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_PER_PHASE = 167;

    typedef struct {
        t_op  op;
        t_pkt pkt;
    } t_word;

    typedef struct {
        logic [4:0]  status;
        logic        tx_valid;
        logic [1:0]  msg_type;
        logic [7:0]  source;
        logic [7:0]  destination;
        logic [7:0]  via;
        logic [15:0] data_value;
        logic [3:0]  ttl;
        logic        app;
        logic        adr;
    } t_answer;

    typedef struct {
        t_word   w;
        t_status st;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic [1:0]  i_msg_type;
    logic [7:0]  i_source;
    logic [7:0]  i_destination;
    logic [15:0] i_data_value;
    logic [3:0]  i_ttl;
    logic        i_app_ack_req;
    logic        i_adr_ack_req;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_status;
    logic        o_tx_valid;
    logic [1:0]  o_tx_msg_type;
    logic [7:0]  o_tx_source;
    logic [7:0]  o_tx_destination;
    logic [7:0]  o_tx_via;
    logic [15:0] o_tx_data_value;
    logic [3:0]  o_tx_ttl;
    logic        o_tx_app_ack_req;
    logic        o_tx_adr_ack_req;

    mesh_flood_forwarder u_top (.*);

    // predictor state
    logic [7:0]  node_id;
    logic        fwd_en;
    logic [15:0] fwd_limit;
    logic [3:0]  max_hops;
    t_pkt        own_fifo[$];
    t_pkt        relay_fifo[$];
    t_pkt        sent_hist[HIST_CAP];
    int          hist_fill;
    int          hist_next;
    int          fwd_total;

    t_answer pending[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      hold_token = 0;
    int      hold_seen = 0;
    int      hold_left = 0;
    int      win_left = 0;
    int      stall_pct = 0;

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_NODE_ID;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_op = OP_NONE;
        i_msg_type = '0;
        i_source = '0;
        i_destination = '0;
        i_data_value = '0;
        i_ttl = '0;
        i_app_ack_req = 1'b0;
        i_adr_ack_req = 1'b0;
        i_stall = 1'b0;
    end

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit same_key(t_pkt a, t_pkt b);
        return a.msg_type == b.msg_type && a.data_value == b.data_value &&
               a.source == b.source && a.destination == b.destination;
    endfunction

    function automatic t_status classify_rx(t_pkt p);
        t_pkt q;
        if (p.destination == node_id)
            return p.msg_type == MT_DATA ? ST_DATA_ME :
                   (p.msg_type == MT_ACK ? ST_ACK_ME : ST_OTHER_ME);
        if (p.source == node_id) return ST_ECHO;
        if (p.msg_type == MT_ACK) return ST_ACK_IGN;
        if (p.msg_type != MT_DATA) return ST_OTHER_IGN;
        if (p.ttl == 4'd0) return ST_EXPIRED;
        if (!fwd_en) return ST_FWD_OFF;
        for (int i = 0; i < hist_fill; i++)
            if (same_key(p, sent_hist[i])) return ST_DUP_HIST;
        foreach (relay_fifo[i])
            if (same_key(p, relay_fifo[i])) return ST_DUP_QUEUE;
        if (relay_fifo.size() >= RELAY_CAP) return ST_FWD_FULL;
        q = p;
        q.ttl = p.ttl - 4'd1;
        relay_fifo.insert(relay_fifo.size(), q);
        return ST_QUEUED;
    endfunction

    function automatic t_answer relay_step(t_word w);
        t_answer a;
        t_pkt    p;
        t_pkt    q;
        a = '{default: '0};
        a.status = ST_NOTHING;
        p = w.pkt;
        case (w.op)
            OP_RX: a.status = classify_rx(p);
            OP_SUBMIT: begin
                if (own_fifo.size() >= OWN_CAP) begin
                    a.status = ST_OWN_FULL;
                end else begin
                    p.source = '0;
                    p.ttl = max_hops;
                    own_fifo.insert(own_fifo.size(), p);
                    a.status = ST_OWN_Q;
                end
            end
            OP_SLOT: begin
                if (own_fifo.size() > 0) begin
                    q = own_fifo.pop_front();
                    q.source = node_id;
                    a.status = ST_SENT_OWN;
                    a.tx_valid = 1'b1;
                end else if (relay_fifo.size() > 0 &&
                             (fwd_limit == 0 || fwd_total < fwd_limit)) begin
                    q = relay_fifo.pop_front();
                    if (fwd_total < 65535) fwd_total++;
                    sent_hist[hist_next] = q;
                    hist_next = (hist_next + 1) % HIST_CAP;
                    if (hist_fill < HIST_CAP) hist_fill++;
                    a.status = ST_SENT_FWD;
                    a.tx_valid = 1'b1;
                end
                if (a.tx_valid) begin
                    a.msg_type = q.msg_type;
                    a.source = q.source;
                    a.destination = q.destination;
                    a.via = node_id;
                    a.data_value = q.data_value;
                    a.ttl = q.ttl;
                    a.app = q.app_ack_req;
                    a.adr = q.adr_ack_req;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_word(t_word w, bit typed, t_status st);
        t_answer a;
        i_valid <= 1'b1;
        i_op <= w.op;
        i_msg_type <= w.pkt.msg_type;
        i_source <= w.pkt.source;
        i_destination <= w.pkt.destination;
        i_data_value <= w.pkt.data_value;
        i_ttl <= w.pkt.ttl;
        i_app_ack_req <= w.pkt.app_ack_req;
        i_adr_ack_req <= w.pkt.adr_ack_req;
        do @(posedge i_clk); while (o_stall);
        a = relay_step(w);
        if (typed) a.status = st;
        pending.insert(pending.size(), a);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NODE_ID:  node_id = val[7:0];
            CFG_FWD_EN:   fwd_en = val[0];
            CFG_FWD_LIM:  fwd_limit = val;
            CFG_MAX_HOPS: max_hops = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_word random_word(int slot_pct);
        t_word w;
        int    r;
        w.pkt.msg_type = 2'($urandom_range(0, 3));
        w.pkt.source = 8'($urandom_range(0, 255));
        w.pkt.destination = 8'($urandom_range(0, 255));
        w.pkt.data_value = 16'($urandom_range(0, 65535));
        w.pkt.ttl = 4'($urandom_range(0, 15));
        w.pkt.app_ack_req = 1'($urandom_range(0, 1));
        w.pkt.adr_ack_req = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < slot_pct) begin
            w.op = OP_SLOT;
        end else if (r < slot_pct + 20) begin
            w.op = OP_SUBMIT;
        end else if (r < slot_pct + 24) begin
            w.op = OP_NONE;
        end else begin
            w.op = OP_RX;
            r = $urandom_range(0, 99);
            if (r < 75) begin
                // relayable data from a small key pool, so duplicates recur
                w.pkt.msg_type = MT_DATA;
                w.pkt.source = 8'($urandom_range(1, 4));
                w.pkt.destination = 8'($urandom_range(8, 11));
                w.pkt.data_value = 16'($urandom_range(0, 7));
                w.pkt.ttl = 4'($urandom_range(1, 15));
            end else if (r < 82) begin
                w.pkt.destination = node_id;
            end else if (r < 88) begin
                w.pkt.source = node_id;
            end
        end
        return w;
    endfunction

    task automatic random_phase(int slot_pct);
        t_word w;
        int    burst;
        int    n;
        n = 0;
        while (n < RANDOM_PER_PHASE) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n < RANDOM_PER_PHASE) begin
                w = random_word(slot_pct);
                send_word(w, 1'b0, ST_NOTHING);
                burst--;
                n++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    endtask

    task automatic set_regs(logic [7:0] id, logic en, logic [15:0] lim, logic [3:0] hops);
        write_reg(CFG_NODE_ID, {8'd0, id});
        write_reg(CFG_FWD_EN, {15'd0, en});
        write_reg(CFG_FWD_LIM, lim);
        write_reg(CFG_MAX_HOPS, {12'd0, hops});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_row mk_row(t_op op, int ty, int src, int dst, int dv, int ttl,
                                    int flags, t_status st);
        t_row r;
        r.w.op = op;
        r.w.pkt.msg_type = 2'(ty);
        r.w.pkt.source = 8'(src);
        r.w.pkt.destination = 8'(dst);
        r.w.pkt.data_value = 16'(dv);
        r.w.pkt.ttl = 4'(ttl);
        r.w.pkt.app_ack_req = flags[0];
        r.w.pkt.adr_ack_req = flags[1];
        r.st = st;
        return r;
    endfunction

    // receiver stall pattern, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (win_left == 0) begin
            win_left = $urandom_range(16, 96);
            stall_pct = $urandom_range(0, 2) * 35;
        end
        win_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                $error("unexpected result word, status %0d", o_status);
                errors++;
            end else begin
                e = pending.pop_front();
                check_field("status", 16'(e.status), 16'(o_status));
                check_field("tx_valid", 16'(e.tx_valid), 16'(o_tx_valid));
                check_field("tx_msg_type", 16'(e.msg_type), 16'(o_tx_msg_type));
                check_field("tx_source", 16'(e.source), 16'(o_tx_source));
                check_field("tx_destination", 16'(e.destination), 16'(o_tx_destination));
                check_field("tx_via", 16'(e.via), 16'(o_tx_via));
                check_field("tx_data_value", e.data_value, o_tx_data_value);
                check_field("tx_ttl", 16'(e.ttl), 16'(o_tx_ttl));
                check_field("tx_app_ack_req", 16'(e.app), 16'(o_tx_app_ack_req));
                check_field("tx_adr_ack_req", 16'(e.adr), 16'(o_tx_adr_ack_req));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("mesh_flood_forwarder verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row dir_rows[$];
        node_id = 8'd0;
        fwd_en = 1'b1;
        fwd_limit = 16'd0;
        max_hops = 4'd3;
        hist_fill = 0;
        hist_next = 0;
        fwd_total = 0;

        dir_rows = {dir_rows, mk_row(OP_SLOT, 0, 0, 0, 0, 0, 0, ST_NOTHING)};
        dir_rows = {dir_rows, mk_row(OP_NONE, 3, 255, 255, 65535, 15, 3, ST_NOTHING)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 9, 0, 1, 5, 0, ST_DATA_ME)};
        dir_rows = {dir_rows, mk_row(OP_RX, 1, 9, 0, 1, 5, 1, ST_ACK_ME)};
        dir_rows = {dir_rows, mk_row(OP_RX, 3, 9, 0, 1, 5, 2, ST_OTHER_ME)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 0, 5, 1, 5, 0, ST_ECHO)};
        dir_rows = {dir_rows, mk_row(OP_RX, 1, 7, 5, 1, 5, 0, ST_ACK_IGN)};
        dir_rows = {dir_rows, mk_row(OP_RX, 2, 7, 5, 1, 5, 0, ST_OTHER_IGN)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 7, 5, 1, 0, 0, ST_EXPIRED)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 255, 255, 65535, 15, 3, ST_QUEUED)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 255, 255, 65535, 15, 3, ST_DUP_QUEUE)};
        dir_rows = {dir_rows, mk_row(OP_SLOT, 0, 0, 0, 0, 0, 0, ST_SENT_FWD)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 255, 255, 65535, 9, 0, ST_DUP_HIST)};
        dir_rows = {dir_rows, mk_row(OP_SUBMIT, 3, 77, 255, 0, 0, 3, ST_OWN_Q)};
        dir_rows = {dir_rows, mk_row(OP_SLOT, 0, 0, 0, 0, 0, 0, ST_SENT_OWN)};
        dir_rows = {dir_rows, mk_row(OP_RX, 0, 1, 2, 0, 1, 0, ST_QUEUED)};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, 1'b1, dir_rows[i].st);
        drain();

        set_regs(8'hff, 1'b1, 16'd0, 4'd15);
        random_phase(25);
        drain();

        set_regs(8'h55, 1'b0, 16'd0, 4'd0);
        hold_token++;
        random_phase(10);
        drain();

        set_regs(8'h00, 1'b1, 16'hffff, 4'd7);
        random_phase(30);
        drain();

        // limit already passed: relay queue fills up
        set_regs(8'haa, 1'b1, 16'd1, 4'd1);
        random_phase(20);
        drain();

        set_regs(8'h3c, 1'b1, 16'd0, 4'd3);
        random_phase(45);
        drain();

        if (errors == 0) begin
            $display("mesh_flood_forwarder verification clean");
        end else begin
            $display("mesh_flood_forwarder verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mff_pkg.sv
rtl/mff_front.sv
rtl/mff_back.sv
rtl/mesh_flood_forwarder.sv
sim/mesh_flood_forwarder_tb.sv
